// ===== hw/rtl/binary_min_heap_extract_top_macros.svh =====
// Assertion macros shared by the heap checker.
`ifndef BINARY_MIN_HEAP_EXTRACT_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_EXTRACT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HMX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hmx_pkg.sv =====
// Shared codes, field widths and types for the min-heap block.
package hmx_pkg;

  localparam int CMD_W  = 2;
  localparam int KEY_W  = 16;
  localparam int SYM_W  = 8;
  localparam int STAT_W = 2;
  localparam int FILL_W = 8;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - STAT_W - KEY_W - SYM_W - FILL_W;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Decision of one sift-down compare step.
  typedef struct packed {
    logic take_child;  // a child moves up into the hole
    logic take_right;  // that child is the right one
  } pick_t;

endpackage

// ===== hw/rtl/hmx_ram.sv =====
// Single-write, single-read entry store with registered read data.
module hmx_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/hmx_sel.sv =====
// Compare unit: picks parent, left or right child for one sift-down level.
module hmx_sel #(
  parameter int KEY_BITS = 16
) (
  input  logic [KEY_BITS-1:0] node_key_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  input  logic                right_ok_i,
  output hmx_pkg::pick_t      pick_o
);

  logic                left_lt;
  logic [KEY_BITS-1:0] best_key;
  logic                right_lt;

  // strict compares: ties keep the parent, then the left child
  assign left_lt  = left_key_i < node_key_i;
  assign best_key = left_lt ? left_key_i : node_key_i;
  assign right_lt = right_ok_i && (right_key_i < best_key);

  assign pick_o.take_child = left_lt | right_lt;
  assign pick_o.take_right = right_lt;

endmodule

// ===== hw/rtl/binary_min_heap_extract_top.sv =====
// Array-held binary min-heap with append, build and extract commands.
//
//   channel  dir  fields (low bit first)
//   s_axis   in   command[1:0] key[17:2] symbol[25:18]
//   m_axis   out  status[1:0] out_key[17:2] out_symbol[25:18] fill_count[33:26]
//
// Append: writes the entry unless full, then sends the result to the output register.
// Extract: reads the root, then the last entry, then sifts down a level at a time; with
// one read port, each level reads left child, then right child, then compares and writes.
// Build: a sift-down of every inner node, from the last one back to the root.
// s_axis_tready is high only while no command is in work; a result held in the
// output register does not block the next transfer until the one after is done.
// Reset clears the entry count and control; the store itself is not cleared.
module binary_min_heap_extract_top #(
  parameter int CAPACITY = 128,
  parameter int KEY_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // command[1:0], key[17:2], symbol[25:18], zero pad
  input  logic [hmx_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], out_key[17:2], out_symbol[25:18], fill_count[33:26], zero pad
  output logic [hmx_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 1;
  localparam int EW = KEY_BITS + hmx_pkg::SYM_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EX_ROOT,
    ST_EX_LAST,
    ST_BLD,
    ST_BLD_LD,
    ST_LEFT,
    ST_RIGHT,
    ST_CMP,
    ST_OUT
  } state_e;

  state_e                           state_q, state_d;
  logic                             bld_op_q, bld_op_d;
  logic [CW-1:0]                    cnt_q, cnt_d;
  logic [AW-1:0]                    idx_q, idx_d;
  logic [AW-1:0]                    bld_q, bld_d;
  logic [EW-1:0]                    node_q, node_d;
  logic [EW-1:0]                    left_q, left_d;
  logic                             rok_q, rok_d;
  logic [hmx_pkg::STAT_W-1:0]       res_stat_q, res_stat_d;
  logic [hmx_pkg::KEY_W-1:0]        res_key_q, res_key_d;
  logic [hmx_pkg::SYM_W-1:0]        res_sym_q, res_sym_d;
  logic                             m_valid_q, m_valid_d;
  logic [hmx_pkg::OUT_TDATA_W-1:0]  m_data_q, m_data_d;

  logic                             s_xfer;
  logic [hmx_pkg::CMD_W-1:0]        in_cmd;
  logic [hmx_pkg::KEY_W-1:0]        in_key;
  logic [hmx_pkg::SYM_W-1:0]        in_sym;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [EW-1:0]                    ram_wdata;
  logic [AW-1:0]                    ram_raddr;
  logic [EW-1:0]                    ram_rdata;

  logic [LW-1:0]                    lc, rc, cnt_w;
  logic                             lc_ok, rc_ok;
  hmx_pkg::pick_t                   pick;
  state_e                           sift_done_st;

  assign in_cmd = s_axis_tdata[1:0];
  assign in_key = s_axis_tdata[17:2];
  assign in_sym = s_axis_tdata[25:18];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign lc    = LW'({idx_q, 1'b1});
  assign rc    = lc + LW'(1);
  assign cnt_w = LW'(cnt_q);
  assign lc_ok = lc < cnt_w;
  assign rc_ok = rc < cnt_w;

  assign sift_done_st = bld_op_q ? ST_BLD : ST_OUT;

  hmx_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hmx_sel #(
    .KEY_BITS (KEY_BITS)
  ) u_sel (
    .node_key_i  (node_q[EW-1:hmx_pkg::SYM_W]),
    .left_key_i  (left_q[EW-1:hmx_pkg::SYM_W]),
    .right_key_i (ram_rdata[EW-1:hmx_pkg::SYM_W]),
    .right_ok_i  (rok_q),
    .pick_o      (pick)
  );

  always_comb begin
    state_d    = state_q;
    bld_op_d   = bld_op_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    bld_d      = bld_q;
    node_d     = node_q;
    left_d     = left_q;
    rok_d      = rok_q;
    res_stat_d = res_stat_q;
    res_key_d  = res_key_q;
    res_sym_d  = res_sym_q;
    m_data_d   = m_data_q;
    m_valid_d  = m_valid_q & ~m_axis_tready;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = node_q;
    ram_raddr  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          res_stat_d = hmx_pkg::STAT_OK;
          res_key_d  = '0;
          res_sym_d  = '0;
          bld_op_d   = 1'b0;
          state_d    = ST_OUT;
          unique case (in_cmd)
            hmx_pkg::CMD_APPEND: begin
              if (cnt_q == CW'(CAPACITY)) begin
                res_stat_d = hmx_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_q);
                ram_wdata = {KEY_BITS'(in_key), in_sym};
                cnt_d     = cnt_q + CW'(1);
              end
            end
            hmx_pkg::CMD_BUILD: begin
              bld_op_d = 1'b1;
              bld_d    = AW'(cnt_q >> 1);
              state_d  = ST_BLD;
            end
            hmx_pkg::CMD_EXTRACT: begin
              if (cnt_q == '0) begin
                res_stat_d = hmx_pkg::STAT_EMPTY;
              end else begin
                ram_raddr = '0;
                state_d   = ST_EX_ROOT;
              end
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_EX_ROOT: begin
        res_key_d = hmx_pkg::KEY_W'(ram_rdata[EW-1:hmx_pkg::SYM_W]);
        res_sym_d = ram_rdata[hmx_pkg::SYM_W-1:0];
        ram_raddr = AW'(cnt_q - CW'(1));
        state_d   = ST_EX_LAST;
      end
      ST_EX_LAST: begin
        // last entry fills the hole at the root
        node_d = ram_rdata;
        cnt_d  = cnt_q - CW'(1);
        idx_d  = '0;
        state_d = (cnt_q == CW'(1)) ? ST_OUT : ST_LEFT;
      end
      ST_BLD: begin
        if (bld_q == '0) begin
          state_d = ST_OUT;
        end else begin
          ram_raddr = bld_q - AW'(1);
          idx_d     = bld_q - AW'(1);
          bld_d     = bld_q - AW'(1);
          state_d   = ST_BLD_LD;
        end
      end
      ST_BLD_LD: begin
        node_d  = ram_rdata;
        state_d = ST_LEFT;
      end
      ST_LEFT: begin
        if (lc_ok) begin
          ram_raddr = lc[AW-1:0];
          state_d   = ST_RIGHT;
        end else begin
          ram_we  = 1'b1;
          state_d = sift_done_st;
        end
      end
      ST_RIGHT: begin
        left_d    = ram_rdata;
        rok_d     = rc_ok;
        ram_raddr = rc_ok ? rc[AW-1:0] : lc[AW-1:0];
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        ram_we = 1'b1;
        if (pick.take_child) begin
          ram_wdata = pick.take_right ? ram_rdata : left_q;
          idx_d     = pick.take_right ? rc[AW-1:0] : lc[AW-1:0];
          state_d   = ST_LEFT;
        end else begin
          state_d = sift_done_st;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {{hmx_pkg::OUT_PAD_W{1'b0}}, hmx_pkg::FILL_W'(cnt_q),
                       res_sym_q, res_key_q, res_stat_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bld_op_q   <= 1'b0;
      cnt_q      <= '0;
      idx_q      <= '0;
      bld_q      <= '0;
      node_q     <= '0;
      left_q     <= '0;
      rok_q      <= 1'b0;
      res_stat_q <= hmx_pkg::STAT_OK;
      res_key_q  <= '0;
      res_sym_q  <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      bld_op_q   <= bld_op_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      bld_q      <= bld_d;
      node_q     <= node_d;
      left_q     <= left_d;
      rok_q      <= rok_d;
      res_stat_q <= res_stat_d;
      res_key_q  <= res_key_d;
      res_sym_q  <= res_sym_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
    end
  end

endmodule

// ===== hw/rtl/hmx_chk.sv =====
// Port-level checker for the min-heap block, bound to the top level.
`include "binary_min_heap_extract_top_macros.svh"

module hmx_chk #(
  parameter int CAPACITY = 128
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [hmx_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                       s_xfer;
  logic [hmx_pkg::STAT_W-1:0] o_stat;
  logic [hmx_pkg::KEY_W-1:0]  o_key;
  logic [hmx_pkg::SYM_W-1:0]  o_sym;
  logic [hmx_pkg::FILL_W-1:0] o_fill;

  assign s_xfer = s_axis_tvalid & s_axis_tready;
  assign o_stat = m_axis_tdata[1:0];
  assign o_key  = m_axis_tdata[17:2];
  assign o_sym  = m_axis_tdata[25:18];
  assign o_fill = m_axis_tdata[33:26];

  // every command keeps the block busy in the cycle after its transfer
  `HMX_ASSERT_NEXT(a_busy_after_xfer, s_xfer, !s_axis_tready, "ready high after transfer")

  `HMX_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  `HMX_ASSERT_NOW(a_full_count, m_axis_tvalid && o_stat == hmx_pkg::STAT_FULL, o_fill == hmx_pkg::FILL_W'(CAPACITY) && o_key == '0, "full status with wrong count")

  `HMX_ASSERT_NOW(a_empty_zero, m_axis_tvalid && o_stat == hmx_pkg::STAT_EMPTY, o_fill == '0 && o_key == '0 && o_sym == '0, "empty status with nonzero fields")

endmodule

bind binary_min_heap_extract_top hmx_chk #(
  .CAPACITY (CAPACITY)
) u_hmx_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
